### src/sqt_pkg.sv
// ----------------------------------------------------------------------------
// sqt_pkg: shared types and codes for the sorted timer queue
// Request and response words, slot contents, chain commands and field codes.
// ----------------------------------------------------------------------------
package sqt_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int MAX_FIRE      = 16;
	localparam int FIRE_CNT_W    = $clog2(MAX_FIRE);
	localparam int TIME_W        = 48;
	localparam int ID_W          = 32;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;
	localparam logic [1:0] KIND_FIRED  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] delay_ticks;
		logic [31:0] timer_id;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] result_id;
		logic [1:0]  status;
		logic [15:0] remaining_ticks;
		logic        last;
	} rsp_word_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0]   ident;
	} slot_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_ADD,
		CMD_CANCEL,
		CMD_POP
	} chain_op_t;

	typedef struct packed {
		chain_op_t         op;
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0]   ident;
	} chain_cmd_t;

endpackage

### src/sqt_cell.sv
// ----------------------------------------------------------------------------
// sqt_cell: one slot of the sorted timer chain
// Holds one timer and shifts toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
module sqt_cell
	import sqt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  chain_cmd_t        cmd,
	input  slot_t             left,
	input  logic              left_le,
	input  slot_t             right,
	input  logic              found_in,
	output slot_t             q,
	output logic              le,
	output logic              found_out,
	output logic [TIME_W-1:0] sel_expiry
);

	logic              valid_q;
	logic [TIME_W-1:0] expiry_q;
	logic [ID_W-1:0]   ident_q;
	slot_t             slot_q;
	slot_t             slot_d;
	logic              match;

	assign slot_q     = '{valid: valid_q, expiry: expiry_q, ident: ident_q};
	assign q          = slot_q;
	assign le         = slot_q.valid && (slot_q.expiry <= cmd.expiry);
	assign match      = slot_q.valid && (slot_q.ident == cmd.ident);
	assign found_out  = found_in | match;
	assign sel_expiry = (match && !found_in) ? slot_q.expiry : '0;

	always_comb begin
		slot_d = slot_q;
		unique case (cmd.op)
			CMD_HOLD: slot_d = slot_q;
			CMD_ADD: begin
				if (le)
					slot_d = slot_q;
				else if (left_le)
					slot_d = '{valid: 1'b1, expiry: cmd.expiry, ident: cmd.ident};
				else
					slot_d = left;
			end
			CMD_CANCEL: begin
				if (found_out)
					slot_d = right;
			end
			CMD_POP: slot_d = right;
			default: slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= slot_d.valid;
	end

	always_ff @(posedge clk) begin
		expiry_q <= slot_d.expiry;
		ident_q  <= slot_d.ident;
	end

endmodule

### src/sqt_chain.sv
// ----------------------------------------------------------------------------
// sqt_chain: row of timer cells kept in expiry order
// Wires neighbors together and gathers head, match and fullness status.
// ----------------------------------------------------------------------------
module sqt_chain
	import sqt_pkg::*;
#(
	parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chain_cmd_t        cmd,
	output slot_t             head,
	output slot_t             second,
	output logic              full,
	output logic              found,
	output logic [TIME_W-1:0] match_expiry
);

	slot_t             cell_q  [TIMER_SLOTS];
	logic              cell_le [TIMER_SLOTS];
	logic              fnd     [TIMER_SLOTS+1];
	logic [TIME_W-1:0] sel     [TIMER_SLOTS];

	assign fnd[0] = 1'b0;

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		slot_t left_s;
		slot_t right_s;
		logic  left_le_s;

		if (i == 0) begin : g_first
			assign left_s    = '0;
			assign left_le_s = 1'b1;
		end else begin : g_mid
			assign left_s    = cell_q[i-1];
			assign left_le_s = cell_le[i-1];
		end

		if (i == TIMER_SLOTS - 1) begin : g_last
			assign right_s = '0;
		end else begin : g_inner
			assign right_s = cell_q[i+1];
		end

		sqt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left       (left_s),
			.left_le    (left_le_s),
			.right      (right_s),
			.found_in   (fnd[i]),
			.q          (cell_q[i]),
			.le         (cell_le[i]),
			.found_out  (fnd[i+1]),
			.sel_expiry (sel[i])
		);
	end

	assign head   = cell_q[0];
	assign second = cell_q[1];
	assign full   = cell_q[TIMER_SLOTS-1].valid;
	assign found  = fnd[TIMER_SLOTS];

	always_comb begin
		match_expiry = '0;
		for (int i = 0; i < TIMER_SLOTS; i++)
			match_expiry = match_expiry | sel[i];
	end

endmodule

### src/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue: sorted table of one-shot timers
// Add, cancel, query and tick operations on a chain of timer cells.
// ----------------------------------------------------------------------------
//  channel  signals                    word
//  request  req_valid / req_ready      req (operation, delay_ticks, timer_id)
//  response rsp_valid / rsp_ready      rsp (kind, result_id, status, ...)
//
//  Add and cancel respond from S_IDLE; a query registers the match, then
//  subtracts in S_QUERY. A tick advances time, then S_FIRE pops due timers.
//  The output register gates request acceptance; fired timers pop the chain
//  head one per response taken. Reset empties the chain and zeroes time/ids.
// ----------------------------------------------------------------------------
module sorted_timer_queue
	import sqt_pkg::*;
#(
	parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_QUERY = 3'b010,
		S_FIRE  = 3'b100
	} state_t;

	state_t                state_q;
	logic [TIME_W-1:0]     time_q;
	logic [ID_W-1:0]       next_id_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic                  found_s1;
	logic [TIME_W-1:0]     expiry_s1;
	logic                  rsp_valid_q;
	rsp_word_t             rsp_q;

	chain_cmd_t        cmd;
	slot_t             head;
	slot_t             second;
	logic              full;
	logic              found;
	logic [TIME_W-1:0] match_expiry;

	logic              out_free;
	logic              accept;
	logic [ID_W-1:0]   new_id;
	logic [TIME_W:0]   add_sum;
	logic [TIME_W-1:0] add_exp;
	logic [TIME_W-1:0] diff;
	logic [15:0]       rem;
	logic              head_due;
	logic              last_fire;
	logic              rsp_load;
	rsp_word_t         rsp_d;

	sqt_chain #(.TIMER_SLOTS(TIMER_SLOTS)) u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.head         (head),
		.second       (second),
		.full         (full),
		.found        (found),
		.match_expiry (match_expiry)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign new_id  = (next_id_q == '1) ? ID_W'(1) : next_id_q + ID_W'(1);
	assign add_sum = {1'b0, time_q} + {{(TIME_W - 32 + 1){1'b0}}, req.delay_ticks};
	assign add_exp = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];

	assign diff = expiry_s1 - time_q;
	always_comb begin
		if (expiry_s1 <= time_q)
			rem = '0;
		else if (diff[TIME_W-1:16] != '0)
			rem = '1;
		else
			rem = diff[15:0];
	end

	assign head_due  = head.valid && (head.expiry <= time_q);
	assign last_fire = (fire_cnt_q == FIRE_CNT_W'(MAX_FIRE - 1)) ||
		!(second.valid && (second.expiry <= time_q));

	always_comb begin
		cmd.op     = CMD_HOLD;
		cmd.expiry = add_exp;
		cmd.ident  = (req.operation == OP_ADD) ? new_id : req.timer_id;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		rsp_d.last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						OP_ADD: begin
							rsp_load   = 1'b1;
							rsp_d.kind = KIND_ADD;
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								cmd.op          = CMD_ADD;
								rsp_d.result_id = new_id;
								rsp_d.status    = ST_OK;
							end
						end
						OP_CANCEL: begin
							rsp_load     = 1'b1;
							rsp_d.kind   = KIND_CANCEL;
							rsp_d.status = found ? ST_OK : ST_NOT_FOUND;
							if (found)
								cmd.op = CMD_CANCEL;
						end
						OP_QUERY, OP_TICK: ;
						default: ;
					endcase
				end
			end
			S_QUERY: begin
				rsp_load              = 1'b1;
				rsp_d.kind            = KIND_QUERY;
				rsp_d.status          = found_s1 ? ST_OK : ST_NOT_FOUND;
				rsp_d.remaining_ticks = found_s1 ? rem : '0;
			end
			S_FIRE: begin
				if (head_due && out_free) begin
					cmd.op          = CMD_POP;
					rsp_load        = 1'b1;
					rsp_d.kind      = KIND_FIRED;
					rsp_d.result_id = head.ident;
					rsp_d.status    = ST_OK;
					rsp_d.last      = last_fire;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			time_q      <= '0;
			next_id_q   <= '0;
			fire_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.operation)
							OP_ADD: begin
								if (!full)
									next_id_q <= new_id;
							end
							OP_CANCEL: ;
							OP_QUERY: state_q <= S_QUERY;
							OP_TICK: begin
								if (time_q != '1)
									time_q <= time_q + TIME_W'(1);
								fire_cnt_q <= '0;
								state_q    <= S_FIRE;
							end
							default: ;
						endcase
					end
				end
				S_QUERY: state_q <= S_IDLE;
				S_FIRE: begin
					if (!head_due) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
						if (last_fire)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_s1  <= found;
			expiry_s1 <= match_expiry;
		end
		if (rsp_load)
			rsp_q <= rsp_d;
	end

endmodule
